FILE: design/ps2mq_pkg.sv
// Shared types and constants for the PS/2 mouse packet event queue.
// Holds the command and error codes and the packed event and status records.
// No dependencies.
`default_nettype none

package ps2mq_pkg;

  typedef enum logic {
    CMD_BYTE = 1'b0,
    CMD_READ = 1'b1
  } cmd_e;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_SYNC     = 2'd1,
    ERR_OVERFLOW = 2'd2
  } err_e;

  localparam int unsigned SyncBit = 3;
  localparam logic [7:0]  OvfMask = 8'hc0;

  typedef struct packed {
    logic [2:0]        buttons;
    logic signed [8:0] dy;
    logic signed [7:0] dx;
  } motion_t;

  typedef struct packed {
    logic    push;
    motion_t motion;
  } evt_t;

  typedef struct packed {
    logic [31:0] seq;
    logic [31:0] tick;
    motion_t     motion;
  } entry_t;

  typedef struct packed {
    logic [1:0]  position;
    err_e        err;
    logic [31:0] bad;
  } par_stat_t;

  typedef struct packed {
    logic [31:0] dropped;
    logic [31:0] latest;
  } ring_stat_t;

endpackage

`default_nettype wire

FILE: design/ps2mq_parser.sv
// Packet assembler: gathers mouse bytes into three-byte packets, checks sync
// and overflow, and forms motion events. Depends on ps2mq_pkg.
`default_nettype none

module ps2mq_parser (
  input  wire logic                 clk_i,
  input  wire logic                 rst_ni,
  input  wire logic                 step_i,
  input  wire logic [7:0]           data_i,
  output ps2mq_pkg::evt_t           evt_o,
  output ps2mq_pkg::par_stat_t      stat_o
);

  typedef enum logic [2:0] {
    POS_HDR = 3'b001,
    POS_X   = 3'b010,
    POS_Y   = 3'b100
  } pos_e;

  pos_e                pos_q, pos_d;
  logic [7:0]          hdr_q, hdr_d;
  logic [7:0]          x_q, x_d;
  logic [2:0]          prev_btn_q, prev_btn_d;
  ps2mq_pkg::err_e     err_q, err_d;
  logic [31:0]         bad_q, bad_d;
  ps2mq_pkg::motion_t  motion;
  logic                push;
  logic [1:0]          pos_index;

  always_comb begin
    motion.dx      = x_q;
    motion.dy      = ~{data_i[7], data_i} + 9'd1;
    motion.buttons = hdr_q[2:0];
    pos_d      = pos_q;
    hdr_d      = hdr_q;
    x_d        = x_q;
    prev_btn_d = prev_btn_q;
    err_d      = err_q;
    bad_d      = bad_q;
    push       = 1'b0;
    if (step_i) begin
      case (pos_q)
        POS_HDR: begin
          if (!data_i[ps2mq_pkg::SyncBit]) begin
            bad_d = bad_q + 32'd1;
            err_d = ps2mq_pkg::ERR_SYNC;
          end else begin
            hdr_d = data_i;
            pos_d = POS_X;
          end
        end
        POS_X: begin
          x_d   = data_i;
          pos_d = POS_Y;
        end
        POS_Y: begin
          pos_d = POS_HDR;
          if ((hdr_q & ps2mq_pkg::OvfMask) != 8'd0) begin
            bad_d = bad_q + 32'd1;
            err_d = ps2mq_pkg::ERR_OVERFLOW;
          end else if (x_q != 8'd0 || data_i != 8'd0 || hdr_q[2:0] != prev_btn_q) begin
            push       = 1'b1;
            prev_btn_d = hdr_q[2:0];
          end
        end
        default: begin
          pos_d = POS_HDR;
        end
      endcase
    end
  end

  always_comb begin
    case (pos_d)
      POS_X:   pos_index = 2'd1;
      POS_Y:   pos_index = 2'd2;
      default: pos_index = 2'd0;
    endcase
  end

  assign evt_o.push     = push;
  assign evt_o.motion   = motion;
  assign stat_o.position = pos_index;
  assign stat_o.err      = err_d;
  assign stat_o.bad      = bad_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= POS_HDR;
      hdr_q      <= 8'd0;
      x_q        <= 8'd0;
      prev_btn_q <= 3'd0;
      err_q      <= ps2mq_pkg::ERR_NONE;
      bad_q      <= 32'd0;
    end else begin
      pos_q      <= pos_d;
      hdr_q      <= hdr_d;
      x_q        <= x_d;
      prev_btn_q <= prev_btn_d;
      err_q      <= err_d;
      bad_q      <= bad_d;
    end
  end

endmodule

`default_nettype wire

FILE: design/ps2mq_ring.sv
// Sequenced event ring: stores events with consecutive sequence numbers,
// overwrites the oldest when full and finds the first event after a cursor.
// Depends on ps2mq_pkg.
`default_nettype none

module ps2mq_ring #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                               clk_i,
  input  wire logic                               rst_ni,
  input  wire logic                               push_i,
  input  wire logic [31:0]                        tick_i,
  input  ps2mq_pkg::motion_t                      motion_i,
  input  wire logic                               read_i,
  input  wire logic [31:0]                        cursor_i,
  output logic                                    found_o,
  output ps2mq_pkg::entry_t                       rd_entry_o,
  output logic [$clog2(QUEUE_DEPTH+1)-1:0]        fill_o,
  output ps2mq_pkg::ring_stat_t                   stat_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [AW-1:0] LastIdx = AW'(QUEUE_DEPTH - 1);
  localparam logic [AW:0]   DepthW  = (AW + 1)'(QUEUE_DEPTH);
  localparam logic [CW-1:0] DepthC  = CW'(QUEUE_DEPTH);

  ps2mq_pkg::entry_t mem [QUEUE_DEPTH];
  ps2mq_pkg::entry_t rd_q;
  ps2mq_pkg::entry_t wr_entry;

  logic [AW-1:0] wp_q, wp_d, rp_q, rp_d;
  logic [CW-1:0] fill_q, fill_d;
  logic [31:0]   drop_q, drop_d, seq_q, seq_d, base_q, base_d, oldest_q, oldest_d;
  logic          full;
  logic [31:0]   off;
  logic          before_oldest, in_range;
  logic [AW-1:0] off_sel, rd_idx;
  logic [AW:0]   idx_sum;

  assign full = (fill_q == DepthC);

  always_comb begin
    wp_d     = wp_q;
    rp_d     = rp_q;
    fill_d   = fill_q;
    drop_d   = drop_q;
    seq_d    = seq_q;
    base_d   = base_q;
    oldest_d = oldest_q;
    if (push_i) begin
      seq_d = seq_q + 32'd1;
      wp_d  = (wp_q == LastIdx) ? '0 : wp_q + AW'(1);
      if (full) begin
        rp_d     = (rp_q == LastIdx) ? '0 : rp_q + AW'(1);
        drop_d   = drop_q + 32'd1;
        base_d   = base_q + 32'd1;
        oldest_d = oldest_q + 32'd1;
      end else begin
        fill_d = fill_q + CW'(1);
      end
    end
  end

  always_comb begin
    off           = cursor_i - base_q;
    before_oldest = (cursor_i < oldest_q);
    in_range      = (off < 32'(fill_q));
    found_o       = (fill_q != '0) && (cursor_i != 32'hffff_ffff) && (before_oldest || in_range);
    off_sel       = before_oldest ? '0 : off[AW-1:0];
    idx_sum       = {1'b0, rp_q} + {1'b0, off_sel};
    rd_idx        = (idx_sum >= DepthW) ? AW'(idx_sum - DepthW) : idx_sum[AW-1:0];
  end

  assign wr_entry.seq    = seq_d;
  assign wr_entry.tick   = tick_i;
  assign wr_entry.motion = motion_i;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem[wp_q] <= wr_entry;
    end
    if (read_i) begin
      rd_q <= mem[rd_idx];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q     <= '0;
      rp_q     <= '0;
      fill_q   <= '0;
      drop_q   <= 32'd0;
      seq_q    <= 32'd0;
      base_q   <= 32'd0;
      oldest_q <= 32'd1;
    end else begin
      wp_q     <= wp_d;
      rp_q     <= rp_d;
      fill_q   <= fill_d;
      drop_q   <= drop_d;
      seq_q    <= seq_d;
      base_q   <= base_d;
      oldest_q <= oldest_d;
    end
  end

  assign rd_entry_o     = rd_q;
  assign fill_o         = fill_d;
  assign stat_o.dropped = drop_d;
  assign stat_o.latest  = seq_d;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= DepthC) else $error("ring fill count above depth");
  a_base_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    base_q == seq_q - 32'(fill_q)) else $error("ring base out of step with sequence");
  a_oldest_track: assert property (@(posedge clk_i) disable iff (!rst_ni)
    oldest_q == base_q + 32'd1) else $error("oldest sequence out of step with base");
  a_seq_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |=> seq_q == $past(seq_q) + 32'd1) else $error("sequence did not advance on push");
  a_no_push_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(push_i && read_i)) else $error("push and read in the same step");
`endif

endmodule

`default_nettype wire

FILE: design/ps2_mouse_packet_event_queue.sv
// A result passes through the input, ring and output stages after its input transfer.
// Throughput: one item per cycle unless stalled; the ring memory has one write and one read port.
// Back-pressure on the output holds a stage only while every stage after it is full.
// Reset clears the parser, ring pointers, counters and stage valids; the ring store is not cleared.
// Depends on ps2mq_pkg, ps2mq_parser and ps2mq_ring.
`default_nettype none

module ps2_mouse_packet_event_queue #(
  parameter int unsigned QUEUE_DEPTH = 64
) (
  input  wire logic                                           clk_i,
  input  wire logic                                           rst_ni,
  input  wire logic                                           s_axis_tvalid,
  output logic                                                s_axis_tready,
  // data_byte[7:0], tick[39:8], cursor[71:40]
  input  wire logic [71:0]                                    s_axis_tdata,
  // command
  input  wire logic                                           s_axis_tuser,
  output logic                                                m_axis_tvalid,
  input  wire logic                                           m_axis_tready,
  // event_seq, event_tick, event_dx, event_dy, event_buttons, pending_events,
  // dropped_events, latest_sequence, sticky_error, bad_packet_count,
  // packet_position, zero fill
  output logic [((184 + $clog2(QUEUE_DEPTH+1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
  // event_found
  output logic                                                m_axis_tuser
);

  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned MW = ((184 + CW + 7) / 8) * 8;

  logic                    v1_q, v2_q, v3_q;
  logic                    adv2, adv3, step, byte_step, read_step;
  ps2mq_pkg::cmd_e         in_cmd_q;
  logic [7:0]              in_data_q;
  logic [31:0]             in_tick_q, in_cursor_q;

  ps2mq_pkg::evt_t         evt;
  ps2mq_pkg::par_stat_t    pstat;
  ps2mq_pkg::ring_stat_t   rstat;
  ps2mq_pkg::entry_t       rd_entry;
  logic                    ring_found;
  logic [CW-1:0]           fill;

  logic                    p_read_q, p_found_q;
  ps2mq_pkg::entry_t       p_entry_q;
  logic [CW-1:0]           p_fill_q;
  ps2mq_pkg::par_stat_t    p_pstat_q;
  ps2mq_pkg::ring_stat_t   p_rstat_q;

  logic                    o_found_q;
  ps2mq_pkg::entry_t       o_entry_q, o_entry_d;
  logic [CW-1:0]           o_fill_q;
  ps2mq_pkg::par_stat_t    o_pstat_q;
  ps2mq_pkg::ring_stat_t   o_rstat_q;

  assign adv3          = !v3_q || m_axis_tready;
  assign adv2          = !v2_q || adv3;
  assign s_axis_tready = !v1_q || adv2;
  assign step          = v1_q && adv2;
  assign byte_step     = step && (in_cmd_q == ps2mq_pkg::CMD_BYTE);
  assign read_step     = step && (in_cmd_q == ps2mq_pkg::CMD_READ);

  ps2mq_parser u_parser (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (byte_step),
    .data_i (in_data_q),
    .evt_o  (evt),
    .stat_o (pstat)
  );

  ps2mq_ring #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_ring (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (evt.push),
    .tick_i     (in_tick_q),
    .motion_i   (evt.motion),
    .read_i     (read_step),
    .cursor_i   (in_cursor_q),
    .found_o    (ring_found),
    .rd_entry_o (rd_entry),
    .fill_o     (fill),
    .stat_o     (rstat)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      if (s_axis_tready) begin
        v1_q <= s_axis_tvalid;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
      if (adv3) begin
        v3_q <= v2_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready) begin
      in_cmd_q    <= ps2mq_pkg::cmd_e'(s_axis_tuser);
      in_data_q   <= s_axis_tdata[7:0];
      in_tick_q   <= s_axis_tdata[39:8];
      in_cursor_q <= s_axis_tdata[71:40];
    end
    if (adv2) begin
      p_read_q         <= (in_cmd_q == ps2mq_pkg::CMD_READ);
      p_found_q        <= (in_cmd_q == ps2mq_pkg::CMD_READ) ? ring_found : evt.push;
      p_entry_q.seq    <= rstat.latest;
      p_entry_q.tick   <= in_tick_q;
      p_entry_q.motion <= evt.motion;
      p_fill_q         <= fill;
      p_pstat_q        <= pstat;
      p_rstat_q        <= rstat;
    end
    if (adv3) begin
      o_found_q <= p_found_q;
      o_entry_q <= o_entry_d;
      o_fill_q  <= p_fill_q;
      o_pstat_q <= p_pstat_q;
      o_rstat_q <= p_rstat_q;
    end
  end

  always_comb begin
    if (!p_found_q) begin
      o_entry_d = '0;
    end else if (p_read_q) begin
      o_entry_d = rd_entry;
    end else begin
      o_entry_d = p_entry_q;
    end
  end

  assign m_axis_tvalid = v3_q;
  assign m_axis_tuser  = o_found_q;
  assign m_axis_tdata  = MW'({o_pstat_q.position, o_pstat_q.bad, o_pstat_q.err,
                              o_rstat_q.latest, o_rstat_q.dropped, o_fill_q,
                              o_entry_q.motion, o_entry_q.tick, o_entry_q.seq});

endmodule

`default_nettype wire
